@@ hw/rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg: shared types, constants and tables of the tone string sequencer
// Widths, reset values, character codes, event codes and the note tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned EVT_W    = 2;
  localparam int unsigned TONE_W   = 15;
  localparam int unsigned DUR_W    = 24;
  localparam int unsigned FULL_W   = 22;
  localparam int unsigned STEP_W   = 10;
  localparam int unsigned OCT_W    = 4;
  localparam int unsigned CORR_W   = 14;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned NOTE_W   = 4;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  typedef logic [SYM_W-1:0]         sym_t;
  typedef logic [EVT_W-1:0]         evt_t;
  typedef logic [TONE_W-1:0]        tone_t;
  typedef logic [DUR_W-1:0]         dur_t;
  typedef logic [FULL_W-1:0]        full_t;
  typedef logic [STEP_W-1:0]        step_t;
  typedef logic [OCT_W-1:0]         oct_t;
  typedef logic signed [CORR_W-1:0] corr_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [NOTE_W-1:0]        note_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [DATA_W-1:0]        data_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    full_t full_note_us;
    step_t tempo_step_us;
  } cfg_t;

  // Contents of the input register.
  typedef struct packed {
    logic valid;
    sym_t symbol;
    logic song_start;
  } in_stage_t;

  // Register indexes (selected by paddr[2]).
  localparam logic REG_FULL_NOTE  = 1'b0;
  localparam logic REG_TEMPO_STEP = 1'b1;

  // Event codes.
  localparam evt_t EVT_TONE       = 2'd0;
  localparam evt_t EVT_REST       = 2'd1;
  localparam evt_t EVT_BAD_SHARP  = 2'd2;
  localparam evt_t EVT_BAD_CHAR   = 2'd3;

  // Reset values and limits.
  localparam full_t FULL_NOTE_RST  = 22'd2000000;
  localparam step_t TEMPO_STEP_RST = 10'd250;
  localparam oct_t  OCT_RST        = 4'd3;
  localparam oct_t  OCT_MAX        = 4'd9;
  localparam oct_t  OCT_MIN        = 4'd0;
  localparam corr_t CORR_RST       = 14'sd0;
  localparam corr_t CORR_MAX       = 14'sh1FFF;
  localparam corr_t CORR_MIN       = 14'sh2000;
  localparam len_t  LEN_RST        = 3'd0;
  localparam len_t  LEN_MAX        = 3'd5;
  localparam note_t NOTE_NONE      = 4'd12;

  // Character codes.
  localparam sym_t CH_DIGIT_0 = 8'h30;
  localparam sym_t CH_DIGIT_9 = 8'h39;
  localparam sym_t CH_UPPER_A = 8'h41;
  localparam sym_t CH_UPPER_G = 8'h47;
  localparam sym_t CH_LOWER_A = 8'h61;
  localparam sym_t CH_LOWER_G = 8'h67;
  localparam sym_t CH_REST    = 8'h70;  // p
  localparam sym_t CH_SLOWER  = 8'h3E;  // >
  localparam sym_t CH_FASTER  = 8'h3C;  // <
  localparam sym_t CH_LEN_0   = 8'h25;  // %
  localparam sym_t CH_LEN_1   = 8'h2A;  // *
  localparam sym_t CH_LEN_2   = 8'h3B;  // ;
  localparam sym_t CH_LEN_3   = 8'h3A;  // :
  localparam sym_t CH_LEN_4   = 8'h2C;  // ,
  localparam sym_t CH_LEN_5   = 8'h2E;  // .
  localparam sym_t CH_OCT_UP  = 8'h2B;  // +
  localparam sym_t CH_OCT_DN  = 8'h2D;  // -

  // Semitone index of a letter. The code is the low three bits of the
  // character, 1 for A up to 7 for G. B and E have no sharp.
  function automatic note_t letter_note(input logic [2:0] code, input logic sharp);
    note_t n;
    n = NOTE_NONE;
    case (code)
      3'd1:    n = sharp ? 4'd1  : 4'd0;
      3'd2:    n = sharp ? NOTE_NONE : 4'd2;
      3'd3:    n = sharp ? 4'd4  : 4'd3;
      3'd4:    n = sharp ? 4'd6  : 4'd5;
      3'd5:    n = sharp ? NOTE_NONE : 4'd7;
      3'd6:    n = sharp ? 4'd9  : 4'd8;
      3'd7:    n = sharp ? 4'd11 : 4'd10;
      default: n = NOTE_NONE;
    endcase
    return n;
  endfunction

  // Truncated frequency of each semitone in the top octave (octave 9).
  // Lower octaves are a right shift of these: the floor of a floor divided
  // by a power of two is the floor of the exact quotient.
  function automatic tone_t top_octave_hz(input note_t n);
    tone_t f;
    f = '0;
    case (n)
      4'd0:    f = 15'd14080;
      4'd1:    f = 15'd14917;
      4'd2:    f = 15'd15804;
      4'd3:    f = 15'd16744;
      4'd4:    f = 15'd17739;
      4'd5:    f = 15'd18794;
      4'd6:    f = 15'd19912;
      4'd7:    f = 15'd21096;
      4'd8:    f = 15'd22350;
      4'd9:    f = 15'd23679;
      4'd10:   f = 15'd25087;
      4'd11:   f = 15'd26579;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tss_if.sv @@
// ----------------------------------------------------------------------------
// tss_if: request channels of the tone string sequencer
// Valid/ready channels for music characters and for the resulting events.
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_in_if;
  logic          valid;
  logic          ready;
  tss_pkg::sym_t symbol;
  logic          song_start;

  modport source (output valid, output symbol, output song_start, input ready);
  modport sink   (input valid, input symbol, input song_start, output ready);
endinterface

interface tss_out_if;
  logic           valid;
  logic           ready;
  tss_pkg::evt_t  event_res;
  tss_pkg::tone_t tone_hz;
  tss_pkg::dur_t  duration_us;

  modport source (output valid, output event_res, output tone_hz, output duration_us,
                  input ready);
  modport sink   (input valid, input event_res, input tone_hz, input duration_us,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tss_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tss_cfg_regs: configuration registers
// Whole-note duration and tempo step, written and read over the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire tss_pkg::addr_t paddr,
  input  wire tss_pkg::data_t pwdata,
  output tss_pkg::data_t      prdata,
  output tss_pkg::cfg_t       cfg
);

  tss_pkg::full_t full_r;
  tss_pkg::step_t step_r;
  logic           wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= tss_pkg::FULL_NOTE_RST;
      step_r <= tss_pkg::TEMPO_STEP_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        tss_pkg::REG_FULL_NOTE:  full_r <= pwdata[tss_pkg::FULL_W-1:0];
        tss_pkg::REG_TEMPO_STEP: step_r <= pwdata[tss_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      tss_pkg::REG_FULL_NOTE:  prdata = tss_pkg::data_t'(full_r);
      tss_pkg::REG_TEMPO_STEP: prdata = tss_pkg::data_t'(step_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.full_note_us  = full_r;
  assign cfg.tempo_step_us = step_r;

endmodule

`default_nettype wire

@@ hw/rtl/tss_exec.sv @@
// ----------------------------------------------------------------------------
// tss_exec: symbol execution stage
// Decodes the registered character, updates the song state and loads the
// result register with the tone, rest or error event.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_exec (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tss_pkg::in_stage_t stage,
  input  wire tss_pkg::cfg_t     cfg,
  output logic                   stage_take,
  tss_out_if.source              out_chan
);

  tss_pkg::oct_t  oct_r, oct_nxt, oct_e;
  tss_pkg::corr_t corr_r, corr_nxt, corr_e;
  tss_pkg::len_t  len_r, len_nxt, len_e;

  logic           out_valid_r;
  tss_pkg::evt_t  evt_r, evt_nxt;
  tss_pkg::tone_t tone_r, tone_nxt;
  tss_pkg::dur_t  dur_r, dur_nxt;

  logic                   has_result;
  logic                   out_free;
  tss_pkg::note_t         note;
  logic signed [24:0]     prod;
  logic signed [25:0]     sum;
  tss_pkg::dur_t          dur_calc;
  tss_pkg::tone_t         tone_calc;

  // Song defaults apply before the character when song_start is set.
  assign oct_e  = stage.song_start ? tss_pkg::OCT_RST  : oct_r;
  assign corr_e = stage.song_start ? tss_pkg::CORR_RST : corr_r;
  assign len_e  = stage.song_start ? tss_pkg::LEN_RST  : len_r;

  // Duration: full note plus signed correction, clamped at zero, then shifted.
  assign prod     = $signed({1'b0, cfg.tempo_step_us}) * corr_e;
  assign sum      = $signed({4'b0000, cfg.full_note_us}) + {prod[24], prod};
  assign dur_calc = sum[25] ? '0 : tss_pkg::dur_t'(sum[24:0] >> len_e);

  assign note      = tss_pkg::letter_note(stage.symbol[2:0], stage.symbol[5]);
  assign tone_calc = tss_pkg::top_octave_hz(note) >> (tss_pkg::OCT_MAX - oct_e);

  always_comb begin
    oct_nxt    = oct_e;
    corr_nxt   = corr_e;
    len_nxt    = len_e;
    has_result = 1'b0;
    evt_nxt    = tss_pkg::EVT_BAD_CHAR;
    tone_nxt   = '0;
    dur_nxt    = '0;
    unique case (stage.symbol) inside
      [tss_pkg::CH_DIGIT_0:tss_pkg::CH_DIGIT_9]: oct_nxt = stage.symbol[3:0];
      [tss_pkg::CH_UPPER_A:tss_pkg::CH_UPPER_G],
      [tss_pkg::CH_LOWER_A:tss_pkg::CH_LOWER_G]: begin
        has_result = 1'b1;
        if (note == tss_pkg::NOTE_NONE) begin
          evt_nxt = tss_pkg::EVT_BAD_SHARP;
        end else begin
          evt_nxt  = tss_pkg::EVT_TONE;
          tone_nxt = tone_calc;
          dur_nxt  = dur_calc;
        end
      end
      tss_pkg::CH_REST: begin
        has_result = 1'b1;
        evt_nxt    = tss_pkg::EVT_REST;
        dur_nxt    = dur_calc;
      end
      tss_pkg::CH_SLOWER: begin
        if (corr_e != tss_pkg::CORR_MIN) corr_nxt = corr_e - 14'sd1;
      end
      tss_pkg::CH_FASTER: begin
        if (corr_e != tss_pkg::CORR_MAX) corr_nxt = corr_e + 14'sd1;
      end
      tss_pkg::CH_LEN_0: len_nxt = 3'd0;
      tss_pkg::CH_LEN_1: len_nxt = 3'd1;
      tss_pkg::CH_LEN_2: len_nxt = 3'd2;
      tss_pkg::CH_LEN_3: len_nxt = 3'd3;
      tss_pkg::CH_LEN_4: len_nxt = 3'd4;
      tss_pkg::CH_LEN_5: len_nxt = tss_pkg::LEN_MAX;
      tss_pkg::CH_OCT_UP: begin
        if (oct_e < tss_pkg::OCT_MAX) oct_nxt = oct_e + 4'd1;
      end
      tss_pkg::CH_OCT_DN: begin
        if (oct_e > tss_pkg::OCT_MIN) oct_nxt = oct_e - 4'd1;
      end
      default: has_result = 1'b1;
    endcase
  end

  // A character that only changes state never waits for the result register.
  assign out_free   = !out_valid_r || out_chan.ready;
  assign stage_take = stage.valid && (!has_result || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r       <= tss_pkg::OCT_RST;
      corr_r      <= tss_pkg::CORR_RST;
      len_r       <= tss_pkg::LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (stage_take) begin
        oct_r  <= oct_nxt;
        corr_r <= corr_nxt;
        len_r  <= len_nxt;
      end
      if (stage_take && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && has_result) begin
      evt_r  <= evt_nxt;
      tone_r <= tone_nxt;
      dur_r  <= dur_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.event_res   = evt_r;
  assign out_chan.tone_hz     = tone_r;
  assign out_chan.duration_us = dur_r;

  a_oct_range : assert property (@(posedge clk) disable iff (!rst_n)
    oct_r <= tss_pkg::OCT_MAX)
    else $error("octave left its range");

  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= tss_pkg::LEN_MAX)
    else $error("length shift left its range");

  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !stage_take |=> $stable(oct_r) && $stable(corr_r) && $stable(len_r))
    else $error("song state changed without a character taken");

  a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (evt_r == tss_pkg::EVT_BAD_SHARP || evt_r == tss_pkg::EVT_BAD_CHAR)
    |-> tone_r == '0 && dur_r == '0)
    else $error("error event carries a tone or duration");

  a_rest_silent : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && evt_r == tss_pkg::EVT_REST |-> tone_r == '0)
    else $error("rest event carries a tone");

endmodule

`default_nettype wire

@@ hw/rtl/tone_string_sequencer.sv @@
// ----------------------------------------------------------------------------
// tone_string_sequencer: music string player, one character per request
// Turns characters of a music string into tone, rest and error events.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one character of the music string per request, with
//   song_start set on the first character of a song to return the octave,
//   tempo correction and note length to their defaults. out_chan carries one
//   event request for each note letter, rest or bad character; digits and
//   the control symbols only change the song state and produce nothing.
//   The APB port holds the whole-note duration and the tempo step; write
//   them only while no character is in flight.
//   An event reaches out_chan through the input register and then the
//   execution stage, whose result register drives out_chan. Throughput is
//   one character per cycle while out_chan takes the events, set by the
//   single execution stage that decodes, updates the state and computes
//   the event in one pass.
//   When the receiver stalls, the event waits in the result register and
//   the input register still drains characters that produce no event; a
//   character that does produce one waits, and in_chan.ready then drops.
//   Reset (synchronous, active low) empties both registers, restores the
//   song defaults and the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_string_sequencer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  tss_in_if.sink              in_chan,
  tss_out_if.source           out_chan,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire tss_pkg::addr_t paddr,
  input  wire tss_pkg::data_t pwdata,
  output tss_pkg::data_t      prdata,
  output logic                pready
);

  tss_pkg::cfg_t      cfg;
  tss_pkg::in_stage_t stage_r;
  logic               stage_take;
  logic               in_ready;
  logic               in_accept;

  assign pready = 1'b1;

  tss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The input register takes a new character whenever it is empty or its
  // current character moves on to the execution stage in the same cycle.
  assign in_ready      = !stage_r.valid || stage_take;
  assign in_chan.ready = in_ready;
  assign in_accept     = in_chan.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (in_accept) begin
      stage_r.valid <= 1'b1;
    end else if (stage_take) begin
      stage_r.valid <= 1'b0;
    end
    // Payload of the input register needs no reset.
    if (in_accept) begin
      stage_r.symbol     <= in_chan.symbol;
      stage_r.song_start <= in_chan.song_start;
    end
  end

  tss_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage_r),
    .cfg        (cfg),
    .stage_take (stage_take),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire
